FILE: hw/rtl/sm3_hash_engine_core_assert.svh
// Assertion macros for the checker file sm3_chk.sv.
`ifndef SM3_HASH_ENGINE_CORE_ASSERT_SVH
`define SM3_HASH_ENGINE_CORE_ASSERT_SVH
// Same-cycle implication, sampled on clk and disabled during reset.
`define SM3_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sm3 assertion failed");
// Next-cycle implication.
`define SM3_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sm3 assertion failed");
`endif

FILE: hw/rtl/sm3_pkg.sv
package sm3_pkg;
	localparam int unsigned LengthBits = 61;

	localparam logic [31:0] Iv [8] = '{
		32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
		32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
	};
	localparam logic [31:0] TjLow  = 32'h79CC4519;
	localparam logic [31:0] TjHigh = 32'h7A879D8A;
	localparam logic [7:0]  PadByte = 8'b10000000;

	typedef enum logic [2:0] {
		ST_IDLE, ST_BYTES, ST_PAD80, ST_PADZ, ST_PADLEN, ST_COMP, ST_FOLD, ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		SRC_DATA, SRC_80, SRC_ZERO, SRC_LEN
	} src_t;

	typedef struct packed {
		logic accept;
		logic wr_byte;
		src_t src;
		logic start_comp;
		logic round;
		logic fold;
		logic reinit;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic fill_56;
		logic done_word;
		logic drop;
		logic cnt_zero;
		logic in_last;
		logic last;
		logic round_last;
	} status_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic logic [31:0] p0(input logic [31:0] x);
		return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction

	function automatic logic [31:0] p1(input logic [31:0] x);
		return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction
endpackage

FILE: hw/rtl/sm3_if.sv
interface sm3_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_word;
	logic [2:0]  byte_count;
	logic        last_word;
	modport source (output valid, data_word, byte_count, last_word, input ready);
	modport sink (input valid, data_word, byte_count, last_word, output ready);
endinterface

interface sm3_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_0;
	logic [63:0] digest_1;
	logic [63:0] digest_2;
	logic [63:0] digest_3;
	logic        length_error;
	modport source (output valid, digest_0, digest_1, digest_2, digest_3, length_error,
		input ready);
	modport sink (input valid, digest_0, digest_1, digest_2, digest_3, length_error,
		output ready);
endinterface

FILE: hw/rtl/sm3_ctrl.sv
module sm3_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  sm3_pkg::status_t   status,
	output sm3_pkg::cmd_t      cmd
);
	sm3_pkg::state_t state_q, state_d, ret_q, ret_d, after;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sm3_pkg::ST_IDLE;
			ret_q   <= sm3_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		after   = sm3_pkg::ST_IDLE;
		unique case (state_q)
			sm3_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (!status.drop && !status.cnt_zero) state_d = sm3_pkg::ST_BYTES;
					else if (status.in_last) state_d = sm3_pkg::ST_PAD80;
				end
			end
			sm3_pkg::ST_BYTES: begin
				if (!status.done_word) after = sm3_pkg::ST_BYTES;
				else if (status.last) after = sm3_pkg::ST_PAD80;
				else after = sm3_pkg::ST_IDLE;
				if (status.full) begin
					state_d = sm3_pkg::ST_COMP;
					ret_d   = after;
				end else begin
					state_d = after;
				end
			end
			sm3_pkg::ST_PAD80: begin
				if (status.full) begin
					state_d = sm3_pkg::ST_COMP;
					ret_d   = sm3_pkg::ST_PADZ;
				end else begin
					state_d = sm3_pkg::ST_PADZ;
				end
			end
			sm3_pkg::ST_PADZ: begin
				if (status.fill_56) begin
					state_d = sm3_pkg::ST_PADLEN;
				end else if (status.full) begin
					state_d = sm3_pkg::ST_COMP;
					ret_d   = sm3_pkg::ST_PADZ;
				end
			end
			sm3_pkg::ST_PADLEN: begin
				if (status.full) begin
					state_d = sm3_pkg::ST_COMP;
					ret_d   = sm3_pkg::ST_OUT;
				end
			end
			sm3_pkg::ST_COMP: begin
				if (status.round_last) state_d = sm3_pkg::ST_FOLD;
			end
			sm3_pkg::ST_FOLD: state_d = ret_q;
			sm3_pkg::ST_OUT: begin
				if (out_ready) state_d = sm3_pkg::ST_IDLE;
			end
			default: state_d = sm3_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd.src   = sm3_pkg::SRC_DATA;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			sm3_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			sm3_pkg::ST_BYTES: begin
				cmd.wr_byte    = 1'b1;
				cmd.start_comp = status.full;
			end
			sm3_pkg::ST_PAD80: begin
				cmd.wr_byte    = 1'b1;
				cmd.src        = sm3_pkg::SRC_80;
				cmd.start_comp = status.full;
			end
			sm3_pkg::ST_PADZ: begin
				cmd.wr_byte    = !status.fill_56;
				cmd.src        = sm3_pkg::SRC_ZERO;
				cmd.start_comp = !status.fill_56 && status.full;
			end
			sm3_pkg::ST_PADLEN: begin
				cmd.wr_byte    = 1'b1;
				cmd.src        = sm3_pkg::SRC_LEN;
				cmd.start_comp = status.full;
			end
			sm3_pkg::ST_COMP: cmd.round = 1'b1;
			sm3_pkg::ST_FOLD: cmd.fold = 1'b1;
			sm3_pkg::ST_OUT: begin
				out_valid  = 1'b1;
				cmd.reinit = out_ready;
			end
			default: cmd = '0;
		endcase
	end
endmodule

FILE: hw/rtl/sm3_dp.sv
module sm3_dp #(
	parameter int unsigned LENGTH_BITS = sm3_pkg::LengthBits
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [31:0]       data_word,
	input  logic [2:0]        byte_count,
	input  logic              last_word,
	input  sm3_pkg::cmd_t     cmd,
	output sm3_pkg::status_t  status,
	output logic [63:0]       digest_0,
	output logic [63:0]       digest_1,
	output logic [63:0]       digest_2,
	output logic [63:0]       digest_3,
	output logic              length_error
);
	logic [31:0] cv_q [8];
	logic [31:0] st_q [8];
	logic [15:0][31:0] buf_q;
	logic [5:0]  fill_q;
	logic [5:0]  round_q;
	logic [LENGTH_BITS-1:0] total_q;
	logic        err_q;
	logic        last_q;
	logic [31:0] word_q;
	logic [2:0]  cnt_q;
	logic [2:0]  k_q;

	logic [2:0]  cnt_in;
	logic [LENGTH_BITS:0] sum;
	logic [63:0] bits;
	logic [7:0]  wbyte;
	logic [31:0] w_new, tj, a12, ss1, ss2, ff, gg, tt1, tt2;

	assign cnt_in = (byte_count > 3'd4) ? 3'd4 : byte_count;
	assign sum    = {1'b0, total_q} + (LENGTH_BITS+1)'(cnt_in);
	assign bits   = 64'(total_q) << 3;

	always_comb begin
		unique case (cmd.src)
			sm3_pkg::SRC_DATA: wbyte = word_q[(3 - k_q[1:0]) * 8 +: 8];
			sm3_pkg::SRC_80:   wbyte = sm3_pkg::PadByte;
			sm3_pkg::SRC_ZERO: wbyte = 8'd0;
			sm3_pkg::SRC_LEN:  wbyte = bits[(7 - fill_q[2:0]) * 8 +: 8];
			default:           wbyte = 8'd0;
		endcase
	end

	// One compression round; buf_q acts as the 16-word expansion window.
	always_comb begin
		w_new = sm3_pkg::p1(buf_q[0] ^ buf_q[7] ^ sm3_pkg::rotl(buf_q[13], 5'd15))
			^ sm3_pkg::rotl(buf_q[3], 5'd7) ^ buf_q[10];
		tj  = (round_q < 6'd16) ? sm3_pkg::TjLow : sm3_pkg::TjHigh;
		a12 = sm3_pkg::rotl(st_q[0], 5'd12);
		ss1 = sm3_pkg::rotl(a12 + st_q[4] + sm3_pkg::rotl(tj, round_q[4:0]), 5'd7);
		ss2 = ss1 ^ a12;
		if (round_q < 6'd16) begin
			ff = st_q[0] ^ st_q[1] ^ st_q[2];
			gg = st_q[4] ^ st_q[5] ^ st_q[6];
		end else begin
			ff = (st_q[0] & st_q[1]) | (st_q[0] & st_q[2]) | (st_q[1] & st_q[2]);
			gg = (st_q[4] & st_q[5]) | (~st_q[4] & st_q[6]);
		end
		tt1 = ff + st_q[3] + ss2 + (buf_q[0] ^ buf_q[4]);
		tt2 = gg + st_q[7] + ss1 + buf_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) cv_q[i] <= sm3_pkg::Iv[i];
			fill_q  <= '0;
			total_q <= '0;
			err_q   <= 1'b0;
			last_q  <= 1'b0;
			round_q <= '0;
			cnt_q   <= '0;
			k_q     <= '0;
		end else begin
			if (cmd.reinit) begin
				for (int i = 0; i < 8; i++) cv_q[i] <= sm3_pkg::Iv[i];
				fill_q  <= '0;
				total_q <= '0;
				err_q   <= 1'b0;
			end
			if (cmd.accept) begin
				last_q <= last_word;
				cnt_q  <= cnt_in;
				k_q    <= '0;
				if (sum[LENGTH_BITS]) err_q <= 1'b1;
				else total_q <= sum[LENGTH_BITS-1:0];
			end
			if (cmd.wr_byte) begin
				fill_q <= fill_q + 6'd1;
				if (cmd.src == sm3_pkg::SRC_DATA) k_q <= k_q + 3'd1;
			end
			if (cmd.start_comp) round_q <= '0;
			else if (cmd.round) round_q <= round_q + 6'd1;
			if (cmd.fold) begin
				for (int i = 0; i < 8; i++) cv_q[i] <= cv_q[i] ^ st_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) word_q <= data_word;
		if (cmd.wr_byte) buf_q[fill_q[5:2]][(3 - fill_q[1:0]) * 8 +: 8] <= wbyte;
		if (cmd.start_comp) begin
			for (int i = 0; i < 8; i++) st_q[i] <= cv_q[i];
		end else if (cmd.round) begin
			for (int i = 0; i < 15; i++) buf_q[i] <= buf_q[i+1];
			buf_q[15] <= w_new;
			st_q[0] <= tt1;
			st_q[1] <= st_q[0];
			st_q[2] <= sm3_pkg::rotl(st_q[1], 5'd9);
			st_q[3] <= st_q[2];
			st_q[4] <= sm3_pkg::p0(tt2);
			st_q[5] <= st_q[4];
			st_q[6] <= sm3_pkg::rotl(st_q[5], 5'd19);
			st_q[7] <= st_q[6];
		end
	end

	always_comb begin
		status            = '0;
		status.full       = fill_q == 6'd63;
		status.fill_56    = fill_q == 6'd56;
		status.done_word  = (k_q + 3'd1) == cnt_q;
		status.drop       = sum[LENGTH_BITS];
		status.cnt_zero   = cnt_in == 3'd0;
		status.in_last    = last_word;
		status.last       = last_q;
		status.round_last = round_q == 6'd63;
	end

	assign digest_0     = {cv_q[0], cv_q[1]};
	assign digest_1     = {cv_q[2], cv_q[3]};
	assign digest_2     = {cv_q[4], cv_q[5]};
	assign digest_3     = {cv_q[6], cv_q[7]};
	assign length_error = err_q;
endmodule

FILE: hw/rtl/sm3_hash_engine_core.sv
// SM3 hash engine. A word is accepted, then its bytes enter the block buffer at one
// byte per cycle, paused while a filled block is compressed.
// Every filled 64-byte block adds a compression: 64 rounds of the single round unit
// plus one fold step; no new word is taken meanwhile. The last word adds padding
// at one byte per cycle, paused likewise, and one or two compressions.
// Reset (arst_n low) loads the initial vector and clears counts and the error flag.
module sm3_hash_engine_core #(
	parameter int unsigned LENGTH_BITS = sm3_pkg::LengthBits
) (
	input logic clk,
	input logic arst_n,
	sm3_in_if.sink    req,
	sm3_out_if.source rsp
);
	sm3_pkg::cmd_t    cmd;
	sm3_pkg::status_t status;

	sm3_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	sm3_dp #(.LENGTH_BITS(LENGTH_BITS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_word    (req.data_word),
		.byte_count   (req.byte_count),
		.last_word    (req.last_word),
		.cmd          (cmd),
		.status       (status),
		.digest_0     (rsp.digest_0),
		.digest_1     (rsp.digest_1),
		.digest_2     (rsp.digest_2),
		.digest_3     (rsp.digest_3),
		.length_error (rsp.length_error)
	);
endmodule

FILE: hw/rtl/sm3_chk.sv
`include "sm3_hash_engine_core_assert.svh"

module sm3_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] out_d0
);
	// The engine never takes a new word while a digest waits.
	`SM3_ASSERT_IMP(no_in_while_out, out_valid, !in_ready)
	// The last word of a message always starts a finalization pass.
	`SM3_ASSERT_NXT(last_blocks_input, in_valid && in_ready && in_last, !in_ready)
	// A pending digest transaction holds until taken.
	`SM3_ASSERT_NXT(out_holds, out_valid && !out_ready, out_valid && $stable(out_d0))
	// After a digest transaction the engine is ready for the next message.
	`SM3_ASSERT_NXT(ready_after_out, out_valid && out_ready, in_ready && !out_valid)
endmodule

bind sm3_hash_engine_core sm3_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.in_last   (req.last_word),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.out_d0    (rsp.digest_0)
);

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	// Byte-count width given to the design under test.
	localparam int unsigned LIMIT_BITS = 16;

	typedef struct {
		logic [63:0] d0;
		logic [63:0] d1;
		logic [63:0] d2;
		logic [63:0] d3;
		logic        err;
	} digest_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sm3_in_if  req_if ();
	sm3_out_if rsp_if ();

	sm3_hash_engine_core #(.LENGTH_BITS(LIMIT_BITS)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if.sink),
		.rsp    (rsp_if.source)
	);

	always #6 clk = ~clk;

	digest_t     pending_digests [$];
	int unsigned error_count = 0;
	int unsigned words_sent = 0;
	bit          no_gaps = 1'b0;
	bit          hold_rsp = 1'b0;

	// Shadow copy of the hash state.
	logic [31:0]     hash_cv [8];
	logic [31:0]     blk_words [16];
	int unsigned     blk_fill;
	longint unsigned msg_bytes;
	bit              msg_err;

	function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned n);
		int unsigned s;
		s = n % 32;
		if (s == 0)
			return x;
		return (x << s) | (x >> (32 - s));
	endfunction

	function automatic void clear_hash();
		for (int i = 0; i < 8; i++)
			hash_cv[i] = sm3_pkg::Iv[i];
		for (int i = 0; i < 16; i++)
			blk_words[i] = '0;
		blk_fill = 0;
		msg_bytes = 0;
		msg_err = 1'b0;
	endfunction

	function automatic void compress_blk();
		logic [31:0] w [68];
		logic [31:0] a, b, c, d, e, f, g, h, tj, a12, ss1, ss2, ff, gg, tt1, tt2;
		for (int j = 0; j < 16; j++)
			w[j] = blk_words[j];
		for (int j = 16; j < 68; j++) begin
			tt1 = w[j-16] ^ w[j-9] ^ rol32(w[j-3], 15);
			w[j] = tt1 ^ rol32(tt1, 15) ^ rol32(tt1, 23) ^ rol32(w[j-13], 7) ^ w[j-6];
		end
		{a, b, c, d, e, f, g, h} = {hash_cv[0], hash_cv[1], hash_cv[2], hash_cv[3],
			hash_cv[4], hash_cv[5], hash_cv[6], hash_cv[7]};
		for (int j = 0; j < 64; j++) begin
			tj = (j < 16) ? 32'h79CC4519 : 32'h7A879D8A;
			a12 = rol32(a, 12);
			ss1 = rol32(a12 + e + rol32(tj, j), 7);
			ss2 = ss1 ^ a12;
			if (j < 16) begin
				ff = a ^ b ^ c;
				gg = e ^ f ^ g;
			end else begin
				ff = (a & b) | (a & c) | (b & c);
				gg = (e & f) | (~e & g);
			end
			tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
			tt2 = gg + h + ss1 + w[j];
			d = c;
			c = rol32(b, 9);
			b = a;
			a = tt1;
			h = g;
			g = rol32(f, 19);
			f = e;
			e = tt2 ^ rol32(tt2, 9) ^ rol32(tt2, 17);
		end
		hash_cv[0] ^= a; hash_cv[1] ^= b; hash_cv[2] ^= c; hash_cv[3] ^= d;
		hash_cv[4] ^= e; hash_cv[5] ^= f; hash_cv[6] ^= g; hash_cv[7] ^= h;
	endfunction

	function automatic void put_byte(input int unsigned pos, input logic [7:0] v);
		int unsigned sh;
		sh = 24 - 8 * (pos % 4);
		blk_words[(pos / 4) % 16] = (blk_words[(pos / 4) % 16] & ~(32'hFF << sh))
			| (32'(v) << sh);
	endfunction

	// Returns 1 and fills the digest when the word closes a message.
	function automatic bit hash_word(input logic [31:0] data, input logic [2:0] cnt,
			input logic last, output digest_t dg);
		int unsigned     n;
		longint unsigned bits;
		n = (cnt > 4) ? 4 : cnt;
		if (msg_bytes + n >= (64'd1 << LIMIT_BITS)) begin
			msg_err = 1'b1;
		end else begin
			msg_bytes += n;
			for (int k = 0; k < n; k++) begin
				put_byte(blk_fill, data[31 - 8*k -: 8]);
				blk_fill++;
				if (blk_fill >= 64) begin
					compress_blk();
					blk_fill = 0;
				end
			end
		end
		if (!last)
			return 1'b0;
		bits = msg_bytes << 3;
		put_byte(blk_fill, sm3_pkg::PadByte);
		for (int p = blk_fill + 1; p < 64; p++)
			put_byte(p, 8'h00);
		if (blk_fill > 55) begin
			compress_blk();
			for (int i = 0; i < 16; i++)
				blk_words[i] = '0;
		end
		blk_words[14] = bits[63:32];
		blk_words[15] = bits[31:0];
		compress_blk();
		dg.d0 = {hash_cv[0], hash_cv[1]};
		dg.d1 = {hash_cv[2], hash_cv[3]};
		dg.d2 = {hash_cv[4], hash_cv[5]};
		dg.d3 = {hash_cv[6], hash_cv[7]};
		dg.err = msg_err;
		clear_hash();
		return 1'b1;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (no_gaps)
			return 0;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_word(input logic [31:0] data, input logic [2:0] cnt,
			input logic last);
		int unsigned gap;
		digest_t     dg;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data_word <= data;
		req_if.byte_count <= cnt;
		req_if.last_word <= last;
		do
			@(posedge clk);
		while (!req_if.ready);
		words_sent++;
		if (hash_word(data, cnt, last, dg))
			pending_digests.push_back(dg);
	endtask

	task automatic idle_input();
		@(negedge clk);
		req_if.valid <= 1'b0;
	endtask

	function automatic logic [31:0] rand_data();
		case ($urandom_range(9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_random_message(input int unsigned max_words);
		int unsigned nw, r;
		logic [2:0]  cnt;
		nw = $urandom_range(1, max_words);
		for (int i = 1; i < nw; i++) begin
			r = $urandom_range(99);
			if (r < 90)
				cnt = 3'd4;
			else if (r < 94)
				cnt = 3'($urandom_range(1, 3));
			else if (r < 97)
				cnt = 3'd0;
			else
				cnt = 3'($urandom_range(5, 7));
			send_word(rand_data(), cnt, 1'b0);
		end
		send_word(rand_data(), 3'($urandom_range(0, 7)), 1'b1);
	endtask

	task automatic test_directed();
		send_word(32'h0, 3'd0, 1'b1);                // empty message
		send_word(32'h6162_6300, 3'd3, 1'b1);        // "abc"
		send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
		send_word(32'h1234_5678, 3'd7, 1'b1);        // count above four
		send_word(32'hA5A5_A5A5, 3'd5, 1'b0);
		send_word(32'h5A00_0000, 3'd1, 1'b0);        // partial word mid-message
		send_word(32'h0, 3'd0, 1'b0);                // empty word mid-message
		send_word(32'hC3C3_0000, 3'd2, 1'b0);
		send_word(32'h7777_7700, 3'd6, 1'b1);
		// 55 and 56 bytes: padding fits in one block or needs a second one.
		for (int i = 0; i < 13; i++)
			send_word($urandom, 3'd4, 1'b0);
		send_word($urandom, 3'd3, 1'b1);
		for (int i = 0; i < 14; i++)
			send_word($urandom, 3'd4, 1'b0);
		send_word(32'h0, 3'd0, 1'b1);
		// Exactly one full block before the padding.
		for (int i = 0; i < 15; i++)
			send_word(32'hFFFF_FFFF, 3'd4, 1'b0);
		send_word(32'h0, 3'd4, 1'b1);
	endtask

	task automatic test_random();
		int unsigned stop_at;
		stop_at = words_sent + 800;
		while (words_sent < stop_at) begin
			no_gaps = ($urandom_range(7) == 0);
			send_random_message(($urandom_range(9) == 0) ? 100 : 30);
		end
		no_gaps = 1'b0;
	endtask

	task automatic test_backpressure();
		hold_rsp = 1'b1;
		no_gaps = 1'b1;
		for (int i = 0; i < 8; i++)
			send_random_message(3);
		no_gaps = 1'b0;
	endtask

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		int unsigned stall;
		int unsigned r;
		rsp_if.ready = 1'b0;
		stall = 0;
		forever begin
			@(negedge clk);
			if (hold_rsp) begin
				rsp_if.ready <= 1'b0;
				repeat (400) @(negedge clk);
				hold_rsp = 1'b0;
			end else if (stall > 0) begin
				rsp_if.ready <= 1'b0;
				stall--;
			end else begin
				r = $urandom_range(99);
				if (no_gaps || r < 80) begin
					rsp_if.ready <= 1'b1;
				end else begin
					rsp_if.ready <= 1'b0;
					stall = (r < 97) ? $urandom_range(0, 3) : $urandom_range(10, 60);
				end
			end
		end
	end

	always @(posedge clk) begin
		digest_t exp_dg;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_digests.size() == 0) begin
				$error("unexpected digest transaction");
				error_count++;
			end else begin
				exp_dg = pending_digests.pop_front();
				if (rsp_if.digest_0 !== exp_dg.d0) begin
					$error("digest_0 expected %h actual %h", exp_dg.d0, rsp_if.digest_0);
					error_count++;
				end
				if (rsp_if.digest_1 !== exp_dg.d1) begin
					$error("digest_1 expected %h actual %h", exp_dg.d1, rsp_if.digest_1);
					error_count++;
				end
				if (rsp_if.digest_2 !== exp_dg.d2) begin
					$error("digest_2 expected %h actual %h", exp_dg.d2, rsp_if.digest_2);
					error_count++;
				end
				if (rsp_if.digest_3 !== exp_dg.d3) begin
					$error("digest_3 expected %h actual %h", exp_dg.d3, rsp_if.digest_3);
					error_count++;
				end
				if (rsp_if.length_error !== exp_dg.err) begin
					$error("length_error expected %b actual %b", exp_dg.err,
						rsp_if.length_error);
					error_count++;
				end
			end
		end
	end

	initial begin
		req_if.valid = 1'b0;
		req_if.data_word = '0;
		req_if.byte_count = '0;
		req_if.last_word = 1'b0;
		clear_hash();
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random();
		test_backpressure();
		idle_input();
		wait (pending_digests.size() == 0);
		repeat (300) @(posedge clk);
		if (error_count == 0 && pending_digests.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("simulation failed");
		$finish;
	end
endmodule
